/* hw/rtl/sacnt_pkg.sv */
// ----------------------------------------------------------------------------
// sacnt_pkg
// Types, sizes and helpers for the subarray AND match counter.
// ----------------------------------------------------------------------------
package sacnt_pkg;

  localparam int unsigned WIDTH   = 32;             // element width
  localparam int unsigned ENTRIES = WIDTH + 1;      // distinct AND values per array
  localparam int unsigned IDX_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CNT_W   = 40;             // per-entry count width
  localparam int unsigned TOT_W   = 64;             // running total width
  localparam int unsigned DATA_W  = 32;             // configuration data width
  localparam int unsigned ADDR_W  = 3;

  // register word index, taken from paddr[2]
  localparam logic [0:0] REG_MATCH_VALUE = 1'b0;

  typedef struct packed {
    logic [WIDTH-1:0] val;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SELF  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

/* hw/rtl/subarray_and_match_counter.sv */
// ----------------------------------------------------------------------------
// subarray_and_match_counter
// Counts contiguous subarrays whose bitwise AND equals match_value.
//
// Input channel (in_valid_i / in_stall_o) takes one array element per request;
// last_element_i closes the array. Output channel (out_valid_o / out_stall_i)
// returns one result per element: matches ending at that element, running
// total for the array, and array_done.
// A table of up to ENTRIES distinct AND values with their counts lives in a
// single-port-read memory. One shared AND / compare / merge unit walks the
// table one entry per cycle, compacting it in place, then folds in the
// element itself and retires the last pending entry.
// From an accepted request to out_valid_o the element passes S_SCAN, which walks
// the n entries in use (0 to ENTRIES), then S_SELF and S_FLUSH. A new request is
// taken only once the previous one is back in S_IDLE; the table walk sets this.
// in_stall_o stays high while an element is in work.
// If the receiver stalls, the result holds in the output register; the next
// element is still accepted and worked on, and waits in its final cycle
// until the output register frees.
// Reset empties the table and clears the total and match_value; no
// clearing pass is needed. Counts saturate at 2^40-1, the total at 2^64-1.
// ----------------------------------------------------------------------------
module subarray_and_match_counter
  import sacnt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // element channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [WIDTH-1:0]  element_i,
  input  logic              last_element_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CNT_W-1:0]  matches_ending_here_o,
  output logic [TOT_W-1:0]  running_total_o,
  output logic              array_done_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_e             state_q, state_d;
  logic [WIDTH-1:0]   match_value_q;
  logic [WIDTH-1:0]   elem_q;
  logic               last_q;
  logic [IDX_W-1:0]   n_q, n_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               dv_q, dv_d;
  entry_t             rd_q;
  logic [IDX_W-1:0]   w_q, w_d;
  entry_t             pend_q, pend_d;
  logic               pend_vld_q, pend_vld_d;
  logic [CNT_W-1:0]   hits_q, hits_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic               out_valid_q, out_valid_d;
  logic [CNT_W-1:0]   out_matches_q;
  logic [TOT_W-1:0]   out_total_q;
  logic               out_done_q;

  entry_t             mem [ENTRIES];

  logic               accept;
  logic               rd_en;
  logic               op_en;
  logic [WIDTH-1:0]   op_val;
  logic [CNT_W-1:0]   op_cnt;
  logic               same;
  logic               wr_en;
  logic               out_free;
  logic               load_out;
  logic               pend_hit;
  logic [CNT_W-1:0]   hits_fin;
  logic [TOT_W:0]     tsum;
  logic [TOT_W-1:0]   tsum_sat;
  logic               cfg_wr;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_en    = (state_q == S_SCAN) && (rd_idx_q < n_q);

  // shared AND / compare / merge unit
  assign op_en    = ((state_q == S_SCAN) && dv_q) || (state_q == S_SELF);
  assign op_val   = (state_q == S_SELF) ? elem_q : (rd_q.val & elem_q);
  assign op_cnt   = (state_q == S_SELF) ? CNT_W'(1) : rd_q.cnt;
  assign same     = pend_vld_q && (pend_q.val == op_val);
  assign pend_hit = pend_q.val == match_value_q;

  assign load_out = (state_q == S_FLUSH) && out_free;
  assign wr_en    = (op_en && pend_vld_q && !same) || load_out;

  assign hits_fin = pend_hit ? pend_q.cnt : hits_q;
  assign tsum     = {1'b0, total_q} + {{(TOT_W + 1 - CNT_W){1'b0}}, hits_fin};
  assign tsum_sat = tsum[TOT_W] ? {TOT_W{1'b1}} : tsum[TOT_W-1:0];

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    rd_idx_d   = rd_idx_q;
    dv_d       = 1'b0;
    w_d        = w_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    hits_d     = hits_q;
    total_d    = total_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_idx_d   = '0;
          w_d        = '0;
          pend_vld_d = 1'b0;
          hits_d     = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        dv_d = rd_en;
        if (rd_en) begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
        if (rd_idx_q == n_q) begin
          state_d = S_SELF;
        end
      end
      S_SELF: begin
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (out_free) begin
          n_d         = w_q + IDX_W'(1);
          total_d     = tsum_sat;
          out_valid_d = 1'b1;
          if (last_q) begin
            n_d     = '0;
            total_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // merge into the pending entry or retire it to the table
    if (op_en) begin
      if (same) begin
        pend_d.cnt = sat_cnt(pend_q.cnt, op_cnt);
      end else begin
        if (pend_vld_q) begin
          w_d = w_q + IDX_W'(1);
          if (pend_hit) begin
            hits_d = pend_q.cnt;
          end
        end
        pend_d.val = op_val;
        pend_d.cnt = op_cnt;
        pend_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      n_q           <= '0;
      rd_idx_q      <= '0;
      dv_q          <= 1'b0;
      w_q           <= '0;
      pend_vld_q    <= 1'b0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
      match_value_q <= '0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      rd_idx_q    <= rd_idx_d;
      dv_q        <= dv_d;
      w_q         <= w_d;
      pend_vld_q  <= pend_vld_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        match_value_q <= pwdata[WIDTH-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    hits_q <= hits_d;
    if (accept) begin
      elem_q <= element_i;
      last_q <= last_element_i;
    end
    if (load_out) begin
      out_matches_q <= hits_fin;
      out_total_q   <= tsum_sat;
      out_done_q    <= last_q;
    end
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[w_q] <= pend_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx_q];
    end
  end

  assign out_valid_o           = out_valid_q;
  assign matches_ending_here_o = out_matches_q;
  assign running_total_o       = out_total_q;
  assign array_done_o          = out_done_q;

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_MATCH_VALUE);
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_MATCH_VALUE) ? match_value_q : '0;

  // compaction never overtakes the read pointer
  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && wr_en) |-> (w_q < rd_idx_q))
    else $error("table write passed the read pointer");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (w_q < IDX_W'(ENTRIES)))
    else $error("table write beyond last entry");

  a_entries_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= IDX_W'(ENTRIES))
    else $error("entry count exceeds table size");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN && w_q == '0 && !pend_vld_q))
    else $error("request did not start a clean table walk");

  a_flush_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> pend_vld_q)
    else $error("no pending entry at flush");

endmodule
